@@ hdl/gpio_pkg.sv @@
// Shared types and constants of the GPIO port register block.
// No dependencies; compile first.
package gpio_pkg;

	localparam int PIN_COUNT = 16;
	localparam int PIN_W     = 4;
	localparam int STEP_W    = 5;
	localparam int DATA_W    = 32;
	localparam int BASE_W    = 10;
	localparam int PNUM_W    = 11;

	localparam logic [DATA_W-1:0] CTL_RESET = 32'h4444_4444;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_DRIVE  = 3'd2,
		OP_TOGGLE = 3'd3,
		OP_SRESET = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_CTL0     = 3'd0,
		REG_CTL1     = 3'd1,
		REG_ISTAT    = 3'd2,
		REG_OCTL     = 3'd3,
		REG_BOP      = 3'd4,
		REG_BC       = 3'd5,
		REG_LOCK     = 3'd6,
		REG_UNMAPPED = 3'd7
	} reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] read_data;
		logic [PNUM_W-1:0] pin_number;
		logic              pin_level;
		logic              pin_is_output;
		logic              last;
	} result_t;

endpackage

@@ hdl/gpio_if.sv @@
// Valid/ready channel interfaces for the GPIO port: one for request beats,
// one for result beats. Depends on gpio_pkg for field widths.
interface gpio_req_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     op;
	logic [2:0]                     reg_index;
	logic [gpio_pkg::DATA_W-1:0]    write_data;
	logic [gpio_pkg::PIN_W-1:0]     pin;
	logic                           level;

	modport source (output valid, op, reg_index, write_data, pin, level, input ready);
	modport sink   (input valid, op, reg_index, write_data, pin, level, output ready);
endinterface

interface gpio_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [gpio_pkg::DATA_W-1:0]    read_data;
	logic [gpio_pkg::PNUM_W-1:0]    pin_number;
	logic                           pin_level;
	logic                           pin_is_output;
	logic                           last;

	modport source (output valid, kind, read_data, pin_number, pin_level, pin_is_output, last,
		input ready);
	modport sink   (input valid, kind, read_data, pin_number, pin_level, pin_is_output, last,
		output ready);
endinterface

@@ hdl/gpio_port_register_block.sv @@
// Top level of the 16-pin GPIO port register block.
// Depends on gpio_pkg and the channel interfaces in gpio_if.sv.
//
// Usage: each request beat on req is one bus write, bus read, external pin
// drive, pin toggle or soft reset. The block answers on rsp with zero or more
// result beats, either read data or pin-change events, and the final beat of a
// request carries last. pin_base is written through cfg_wr_en/cfg_wr_data
// while the block is idle and is added to the local pin index of each event.
//
// Timing: a request is registered in the cycle it is accepted, then one
// shared pin-step unit runs once per cycle, unless a stalled receiver holds
// it, over the affected positions: one step for reads, drives and toggles,
// 8 for CTL0/CTL1, 16 for OCTL, BC and soft reset, 32 for BOP (set half, then
// clear half). A flush state then hands the last result to the output
// register, and the next request is taken after that; ready is low while a
// request is being worked on.
//
// One event is held back in a pending register until the next event or the
// end of the scan, so that last can be set on it. When the receiver stalls,
// the output register holds its beat and the scan waits rather than drop an
// event. Reset restores CTL0/CTL1 to 0x44444444, clears ISTAT, OCTL and
// pin_base, and leaves the block idle with no result pending.
module gpio_port_register_block (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gpio_pkg::BASE_W-1:0]   cfg_wr_data,
	gpio_req_if.sink                      req,
	gpio_rsp_if.source                    rsp
);
	import gpio_pkg::*;

	// Architectural state.
	logic [DATA_W-1:0]    ctl_lo_q, ctl_hi_q;
	logic [PIN_COUNT-1:0] istat_q, octl_q;
	logic [BASE_W-1:0]    pin_base_q;

	// Captured request.
	logic [2:0]           cmd_op_q;
	logic [2:0]           cmd_reg_q;
	logic [DATA_W-1:0]    cmd_wd_q;
	logic [PIN_W-1:0]     cmd_pin_q;
	logic                 cmd_lvl_q;

	// Sequencer.
	state_t               state_q, state_n;
	logic [STEP_W-1:0]    idx_q, last_idx_q, last_idx_n;

	// Pending event and output register.
	result_t              pend_q, out_q, step_res, out_d;
	logic                 pend_vld_q, out_vld_q;

	// Control decoded by the sequencer.
	logic                 accept, out_free, step_go, step_hit;
	logic                 out_load, out_last, pend_load, pend_clear;
	logic                 ctl_we, latch_we, istat_we;
	logic                 latch_bit, istat_bit;

	// Pin-step unit signals.
	logic [PIN_W-1:0]     step_pin;
	logic [3:0]           cur_nib, new_nib;
	logic                 cur_mode, new_mode;
	logic [PNUM_W-1:0]    step_pnum;

	assign out_free = !out_vld_q || rsp.ready;
	assign accept   = req.valid && req.ready;

	// The pin-step unit: one pin position per cycle, unless a stalled output holds the scan.
	always_comb begin
		if (cmd_op_q == OP_DRIVE || cmd_op_q == OP_TOGGLE) begin
			step_pin = cmd_pin_q;
		end else if (cmd_op_q == OP_WRITE && (cmd_reg_q == REG_CTL0 || cmd_reg_q == REG_CTL1))
		begin
			step_pin = {cmd_reg_q[0], idx_q[2:0]};
		end else begin
			step_pin = idx_q[PIN_W-1:0];
		end
	end

	assign cur_nib   = step_pin[3] ? ctl_hi_q[{step_pin[2:0], 2'b00} +: 4]
	                               : ctl_lo_q[{step_pin[2:0], 2'b00} +: 4];
	assign cur_mode  = |cur_nib[1:0];
	assign new_nib   = cmd_wd_q[{idx_q[2:0], 2'b00} +: 4];
	assign new_mode  = |new_nib[1:0];
	assign step_pnum = {1'b0, pin_base_q} + {{(PNUM_W-PIN_W){1'b0}}, step_pin};

	always_comb begin
		step_hit  = 1'b0;
		ctl_we    = 1'b0;
		latch_we  = 1'b0;
		istat_we  = 1'b0;
		latch_bit = 1'b0;
		istat_bit = 1'b0;
		step_res  = '0;
		step_res.kind       = KIND_EVENT;
		step_res.pin_number = step_pnum;
		case (cmd_op_q)
			OP_WRITE: begin
				case (cmd_reg_q)
					REG_CTL0, REG_CTL1: begin
						ctl_we   = 1'b1;
						step_hit = new_mode != cur_mode;
						step_res.pin_level     = new_mode ? octl_q[step_pin] : istat_q[step_pin];
						step_res.pin_is_output = new_mode;
					end
					REG_OCTL: begin
						latch_we  = 1'b1;
						latch_bit = cmd_wd_q[idx_q];
					end
					REG_BOP: begin
						latch_we  = cmd_wd_q[idx_q];
						latch_bit = !idx_q[STEP_W-1];
					end
					REG_BC: begin
						latch_we  = cmd_wd_q[idx_q];
						latch_bit = 1'b0;
					end
					default: begin
					end
				endcase
				// A latch write shows only on output pins.
				if (latch_we && cur_mode && octl_q[step_pin] != latch_bit) begin
					step_hit = 1'b1;
					step_res.pin_level     = latch_bit;
					step_res.pin_is_output = 1'b1;
				end
			end
			OP_READ: begin
				step_hit      = 1'b1;
				step_res      = '0;
				step_res.kind = KIND_READ;
				case (cmd_reg_q)
					REG_CTL0:  step_res.read_data = ctl_lo_q;
					REG_CTL1:  step_res.read_data = ctl_hi_q;
					REG_ISTAT: step_res.read_data = {{(DATA_W-PIN_COUNT){1'b0}}, istat_q};
					REG_OCTL:  step_res.read_data = {{(DATA_W-PIN_COUNT){1'b0}}, octl_q};
					default:   step_res.read_data = '0;
				endcase
			end
			OP_DRIVE, OP_TOGGLE: begin
				istat_bit = (cmd_op_q == OP_DRIVE) ? cmd_lvl_q : !istat_q[step_pin];
				if (!cur_mode) begin
					istat_we = 1'b1;
					step_hit = 1'b1;
					step_res.pin_level = istat_bit;
				end
			end
			OP_SRESET: begin
				step_hit = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: next state and handoff between pending and output registers.
	always_comb begin
		state_n    = state_q;
		step_go    = 1'b0;
		out_load   = 1'b0;
		out_last   = 1'b0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		last_idx_n = '0;
		req.ready  = 1'b0;
		case (op_t'(req.op))
			OP_WRITE: begin
				case (reg_t'(req.reg_index))
					REG_CTL0, REG_CTL1: last_idx_n = STEP_W'(7);
					REG_OCTL, REG_BC:   last_idx_n = STEP_W'(PIN_COUNT - 1);
					REG_BOP:            last_idx_n = STEP_W'(2 * PIN_COUNT - 1);
					default:            last_idx_n = '0;
				endcase
			end
			OP_SRESET: last_idx_n = STEP_W'(PIN_COUNT - 1);
			default:   last_idx_n = '0;
		endcase
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// A new event may push the pending one out only into a free output.
				if (!pend_vld_q || out_free) begin
					step_go = 1'b1;
					if (step_hit) begin
						pend_load = 1'b1;
						out_load  = pend_vld_q;
					end
					if (idx_q == last_idx_q) begin
						state_n = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_vld_q) begin
					state_n = ST_IDLE;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_last   = 1'b1;
					pend_clear = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			last_idx_q <= '0;
		end else if (accept) begin
			idx_q      <= '0;
			last_idx_q <= last_idx_n;
		end else if (step_go) begin
			idx_q <= idx_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_op_q  <= req.op;
			cmd_reg_q <= req.reg_index;
			cmd_wd_q  <= req.write_data;
			cmd_pin_q <= req.pin;
			cmd_lvl_q <= req.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_base_q <= '0;
		end else if (cfg_wr_en) begin
			pin_base_q <= cfg_wr_data;
		end
	end

	// Port registers; soft reset takes effect when the request is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_lo_q <= CTL_RESET;
			ctl_hi_q <= CTL_RESET;
			istat_q  <= '0;
			octl_q   <= '0;
		end else if (accept && req.op == OP_SRESET) begin
			ctl_lo_q <= CTL_RESET;
			ctl_hi_q <= CTL_RESET;
			istat_q  <= '0;
			octl_q   <= '0;
		end else if (step_go) begin
			if (ctl_we) begin
				if (step_pin[3]) begin
					ctl_hi_q[{step_pin[2:0], 2'b00} +: 4] <= new_nib;
				end else begin
					ctl_lo_q[{step_pin[2:0], 2'b00} +: 4] <= new_nib;
				end
			end
			if (latch_we) begin
				octl_q[step_pin] <= latch_bit;
			end
			if (istat_we) begin
				istat_q[step_pin] <= istat_bit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (step_go && pend_load) begin
			pend_vld_q <= 1'b1;
		end else if (pend_clear) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && pend_load) begin
			pend_q <= step_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// The pending beat moves to the output with last set only at the end of a scan.
	always_comb begin
		out_d      = pend_q;
		out_d.last = out_last;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.kind          = out_q.kind;
	assign rsp.read_data     = out_q.read_data;
	assign rsp.pin_number    = out_q.pin_number;
	assign rsp.pin_level     = out_q.pin_level;
	assign rsp.pin_is_output = out_q.pin_is_output;
	assign rsp.last          = out_q.last;

endmodule

@@ bench/gpio_event_checker.sv @@
// Checker for the GPIO port register block: keeps its own copy of the port
// registers, predicts the result beats of every accepted request and compares them.
// Depends on gpio_pkg and the channel interfaces in gpio_if.sv.
module gpio_event_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gpio_pkg::BASE_W-1:0] cfg_wr_data,
	gpio_req_if                         req,
	gpio_rsp_if                         rsp,
	output int                          fail_count,
	output int                          pending
);
	import gpio_pkg::*;

	localparam int REPORT_CAP = 40;

	logic [DATA_W-1:0]    ctl_lo;
	logic [DATA_W-1:0]    ctl_hi;
	logic [PIN_COUNT-1:0] istat;
	logic [PIN_COUNT-1:0] octl;
	logic [BASE_W-1:0]    base;
	result_t              port_reports[$];

	function automatic logic is_output(int p);
		logic [DATA_W-1:0] ctl;
		ctl = (p < 8) ? ctl_lo : ctl_hi;
		return ctl[(p % 8) * 4 +: 2] != 2'b00;
	endfunction

	function automatic logic level_of(int p);
		return is_output(p) ? octl[p] : istat[p];
	endfunction

	// Every event carries the level and mode of the pin as they stand after the change.
	function automatic void report_pin(int p);
		result_t r;
		r = '0;
		r.kind          = KIND_EVENT;
		r.pin_number    = PNUM_W'(base) + PNUM_W'(p);
		r.pin_level     = level_of(p);
		r.pin_is_output = is_output(p);
		port_reports.push_back(r);
	endfunction

	function automatic void clear_port();
		ctl_lo = CTL_RESET;
		ctl_hi = CTL_RESET;
		istat  = '0;
		octl   = '0;
	endfunction

	function automatic void set_latch(int p, logic v);
		logic was;
		was = level_of(p);
		octl[p] = v;
		if (level_of(p) != was) begin
			report_pin(p);
		end
	endfunction

	function automatic void write_ctl(int half, logic [DATA_W-1:0] v);
		int   p;
		logic was;
		for (int i = 0; i < 8; i++) begin
			p = half * 8 + i;
			was = is_output(p);
			if (half == 1) begin
				ctl_hi[i * 4 +: 4] = v[i * 4 +: 4];
			end else begin
				ctl_lo[i * 4 +: 4] = v[i * 4 +: 4];
			end
			if (is_output(p) != was) begin
				report_pin(p);
			end
		end
	endfunction

	// Output pins ignore external drive; input pins report even an unchanged level.
	function automatic void drive_pin(int p, logic v);
		if (!is_output(p)) begin
			istat[p] = v;
			report_pin(p);
		end
	endfunction

	function automatic void predict_port_response(logic [2:0] op, logic [2:0] rix,
			logic [DATA_W-1:0] wd, logic [PIN_W-1:0] p, logic lvl);
		int      first;
		result_t rd;
		first = port_reports.size();
		rd = '0;
		rd.kind = KIND_READ;
		case (op)
			OP_WRITE: begin
				case (rix)
					REG_CTL0: write_ctl(0, wd);
					REG_CTL1: write_ctl(1, wd);
					REG_OCTL: begin
						for (int i = 0; i < PIN_COUNT; i++) set_latch(i, wd[i]);
					end
					REG_BOP: begin
						// The set half is applied before the clear half.
						for (int i = 0; i < 2 * PIN_COUNT; i++) begin
							if (wd[i]) set_latch(i % PIN_COUNT, i < PIN_COUNT);
						end
					end
					REG_BC: begin
						for (int i = 0; i < PIN_COUNT; i++) begin
							if (wd[i]) set_latch(i, 1'b0);
						end
					end
					default: ;
				endcase
			end
			OP_READ: begin
				case (rix)
					REG_CTL0:  rd.read_data = ctl_lo;
					REG_CTL1:  rd.read_data = ctl_hi;
					REG_ISTAT: rd.read_data = DATA_W'(istat);
					REG_OCTL:  rd.read_data = DATA_W'(octl);
					default:   rd.read_data = '0;
				endcase
				port_reports.push_back(rd);
			end
			OP_DRIVE:  drive_pin(p, lvl);
			OP_TOGGLE: drive_pin(p, !level_of(p));
			OP_SRESET: begin
				clear_port();
				for (int i = 0; i < PIN_COUNT; i++) report_pin(i);
			end
			default: ;
		endcase
		if (port_reports.size() > first) begin
			port_reports[port_reports.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic string show(result_t r);
		return $sformatf("kind %b data %h pin %0d level %b output %b last %b", r.kind,
			r.read_data, r.pin_number, r.pin_level, r.pin_is_output, r.last);
	endfunction

	function automatic void check_beat();
		result_t got;
		result_t want;
		got = {rsp.kind, rsp.read_data, rsp.pin_number, rsp.pin_level, rsp.pin_is_output,
			rsp.last};
		if (port_reports.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_CAP) begin
				$display("%0t: result beat with nothing awaited, actual %s", $time, show(got));
			end
		end else begin
			want = port_reports.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= REPORT_CAP) begin
					$display("%0t: mismatch, expected %s", $time, show(want));
					$display("%0t: mismatch, actual   %s", $time, show(got));
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_port();
			base = '0;
			port_reports.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) check_beat();
			if (cfg_wr_en) base = cfg_wr_data;
			if (req.valid && req.ready) begin
				predict_port_response(req.op, req.reg_index, req.write_data, req.pin, req.level);
			end
			pending = port_reports.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// Top of the GPIO port register block bench: clock, reset, request stimulus,
// receiver stalls and the verdict. Depends on gpio_pkg, gpio_if.sv, the block
// itself and gpio_event_checker.
module testbench;
	import gpio_pkg::*;

	// Generous bound on the whole run; a correct run needs far fewer cycles even when
	// every request causes its most beats and the receiver stalls often.
	localparam int CYCLE_LIMIT = 400000;
	// Waiting DRAIN_CYCLES after the last awaited beat makes sure that a request
	// that causes no beat has also finished.
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 62;

	// Op codes that the block does not define; it must ignore them.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [BASE_W-1:0] cfg_wr_data;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                fail_count;
	int                pending;

	gpio_req_if req_ch ();
	gpio_rsp_if rsp_ch ();

	gpio_port_register_block u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	gpio_event_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver decides afresh at every edge whether to take a beat, so its stalls
	// land on every phase of a scan, including while a beat is held back for last.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a hung handshake or a lost beat ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("gpio_port_register_block test failed");
		$finish;
	end

	// Presents one request beat and returns at the edge that accepts it. Valid stays
	// high on return, so a request that follows at once is not split by a low cycle;
	// the sender's idle cycles are the only place where valid drops.
	task automatic send_request(logic [2:0] op, logic [2:0] rix, logic [DATA_W-1:0] wd,
			logic [PIN_W-1:0] p, logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.reg_index  <= rix;
		req_ch.write_data <= wd;
		req_ch.pin        <= p;
		req_ch.level      <= lvl;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Holds the sender off until every awaited beat has come back. The first wait is
	// an edge, so the checker has already booked the last accepted request.
	task automatic wait_quiet();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// pin_base may only change while the block is idle, so the block is drained first.
	task automatic set_pin_base(logic [BASE_W-1:0] v);
		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Random requests lean toward writes, drives and toggles, which are what move the
	// pins; control writes with random nibbles keep switching pins between the modes,
	// so that latch writes and drives meet both inputs and outputs. Soft resets and
	// undefined ops are mixed in at a low rate.
	task automatic random_request();
		int         pick;
		logic [2:0] op;
		pick = $urandom_range(99);
		if (pick < 34) begin
			op = OP_WRITE;
		end else if (pick < 50) begin
			op = OP_READ;
		end else if (pick < 72) begin
			op = OP_DRIVE;
		end else if (pick < 91) begin
			op = OP_TOGGLE;
		end else if (pick < 96) begin
			op = OP_SRESET;
		end else begin
			op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		end
		send_request(op, 3'($urandom_range(REG_UNMAPPED, REG_CTL0)), DATA_W'($urandom),
			PIN_W'($urandom_range(PIN_COUNT - 1)), 1'($urandom_range(1)));
	endtask

	// One phase of random requests under one idling pattern and one pin_base. Halfway
	// through, the sender pauses until every awaited beat has come.
	task automatic run_phase(int idle, int stall, logic [BASE_W-1:0] base_v);
		set_pin_base(base_v);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if (k == PHASE_ITEMS / 2) wait_quiet();
			random_request();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		req_ch.valid       = 1'b0;
		req_ch.op          = OP_READ;
		req_ch.reg_index   = REG_CTL0;
		req_ch.write_data  = '0;
		req_ch.pin         = '0;
		req_ch.level       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with the largest pin_base so that event pin numbers reach
		// their top value.
		set_pin_base('1);

		// Reset contents of every register, mapped or not.
		for (int r = REG_CTL0; r <= REG_UNMAPPED; r++) begin
			send_request(OP_READ, 3'(r), '0, '0, 1'b0);
		end

		// Drives and a toggle of input pins; driving pin 15 low reports although the
		// level does not change.
		send_request(OP_DRIVE, REG_CTL0, '0, 4'd0, 1'b1);
		send_request(OP_DRIVE, REG_CTL0, '0, 4'd15, 1'b0);
		send_request(OP_TOGGLE, REG_CTL0, '0, 4'd9, 1'b0);

		// Writes that the block ignores.
		send_request(OP_WRITE, REG_ISTAT, '1, '0, 1'b0);
		send_request(OP_WRITE, REG_LOCK, '1, '0, 1'b0);
		send_request(OP_WRITE, REG_UNMAPPED, '1, '0, 1'b0);

		// Pins 0-7 become outputs; pins 8-15 get every mode encoding.
		send_request(OP_WRITE, REG_CTL0, 32'h1111_1111, '0, 1'b0);
		send_request(OP_WRITE, REG_CTL1, 32'hFEDC_BA98, '0, 1'b0);

		// Latch writes: all ones, then set and clear of every pin in one write, where
		// the clear half must win, then set only, clear only and a mixed pattern.
		send_request(OP_WRITE, REG_OCTL, '1, '0, 1'b0);
		send_request(OP_WRITE, REG_BOP, '1, '0, 1'b0);
		send_request(OP_WRITE, REG_BOP, 32'h0000_FFFF, '0, 1'b0);
		send_request(OP_WRITE, REG_BC, '1, '0, 1'b0);
		send_request(OP_WRITE, REG_BOP, 32'hAAAA_5555, '0, 1'b0);

		// Drive and toggle of an output pin are ignored; pin 12 is still an input.
		send_request(OP_DRIVE, REG_CTL0, '0, 4'd1, 1'b1);
		send_request(OP_TOGGLE, REG_CTL0, '0, 4'd1, 1'b0);
		send_request(OP_TOGGLE, REG_CTL0, '0, 4'd12, 1'b0);

		send_request(OP_READ, REG_CTL1, '0, '0, 1'b0);
		send_request(OP_READ, REG_OCTL, '0, '0, 1'b0);
		send_request(OP_READ, REG_ISTAT, '0, '0, 1'b0);

		// Undefined ops cause nothing; soft reset reports all 16 pins.
		send_request(OP_SPARE_LO, REG_CTL0, '1, '1, 1'b1);
		send_request(OP_SPARE_HI, REG_CTL1, '1, '1, 1'b1);
		send_request(OP_SRESET, REG_CTL0, '0, '0, 1'b0);

		// Random part: no idling, then sender gaps, then receiver stalls, then both.
		run_phase(0, 0, '0);
		run_phase(63, 0, BASE_W'($urandom));
		run_phase(0, 63, '1);
		run_phase(16, 16, BASE_W'($urandom));

		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("gpio_port_register_block test passed");
		end else begin
			$display("gpio_port_register_block test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/gpio_pkg.sv
hdl/gpio_if.sv
hdl/gpio_port_register_block.sv
bench/gpio_event_checker.sv
bench/testbench.sv
